>>> hdl/led_cube_command_frame_store_unit_assert.svh
// ----------------------------------------------------------------------------
// LED cube frame store assertion macros
// Concurrent assertion helpers used by the checker file.
// ----------------------------------------------------------------------------
`ifndef LED_CUBE_COMMAND_FRAME_STORE_UNIT_ASSERT_SVH
`define LED_CUBE_COMMAND_FRAME_STORE_UNIT_ASSERT_SVH

// Generic clocked assertion with asynchronous active-low reset.
`define LCFS_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error("lcfs: assertion failed");

// A stalled valid item holds its payload.
`define LCFS_ASSERT_HOLD(lbl, clk, rstn, vld, rdy, sig) \
  `LCFS_ASSERT(lbl, clk, rstn, (vld && !rdy) |=> (vld && $stable(sig)))

`endif

>>> hdl/lcfs_pkg.sv
// ----------------------------------------------------------------------------
// LED cube frame store package
// Shared types, codes and constants of the frame store unit.
// ----------------------------------------------------------------------------
`default_nettype none

package lcfs_pkg;

  localparam int unsigned LAYERS    = 4;
  localparam int unsigned LANES     = 16;
  localparam int unsigned ROWS      = 4;
  localparam int unsigned VOXELS    = 64;
  localparam int unsigned INT_W     = 7;
  localparam logic [7:0]  TMO_RELOAD = 8'd255;

  typedef enum logic [1:0] {
    OP_BYTE  = 2'd0,
    OP_PLANE = 2'd1,
    OP_TICK  = 2'd2,
    OP_NONE  = 2'd3
  } lcfs_op_e;

  typedef enum logic [5:0] {
    CMD_HOME  = 6'd0,
    CMD_OFF   = 6'd1,
    CMD_ON    = 6'd2,
    CMD_NEXT  = 6'd3,
    CMD_CLEAR = 6'd4,
    CMD_PING  = 6'd5
  } lcfs_cmd_e;

  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } lcfs_state_e;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic exec;
  } lcfs_ctl_t;

  // voxel lane to driver bit
  localparam logic [3:0] DRV_MAP [LANES] = '{
    4'd11, 4'd8,  4'd7, 4'd4,
    4'd12, 4'd9,  4'd6, 4'd3,
    4'd13, 4'd10, 4'd5, 4'd2,
    4'd14, 4'd15, 4'd0, 4'd1
  };

endpackage

`default_nettype wire

>>> hdl/lcfs_if.sv
// ----------------------------------------------------------------------------
// LED cube frame store channels
// Valid/ready channel interfaces for items and results.
// ----------------------------------------------------------------------------
`default_nettype none

interface lcfs_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] op;
  logic [7:0] rx_byte;
  logic [1:0] layer_sel;
  logic [2:0] plane_sel;

  modport source (output valid, op, rx_byte, layer_sel, plane_sel, input ready);
  modport sink   (input valid, op, rx_byte, layer_sel, plane_sel, output ready);
endinterface

interface lcfs_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] plane_word;
  logic        lamp_on;
  logic [1:0]  pattern_select;
  logic        host_active;
  logic [5:0]  write_position;

  modport source (output valid, plane_word, lamp_on, pattern_select, host_active,
                  write_position, input ready);
  modport sink   (input valid, plane_word, lamp_on, pattern_select, host_active,
                  write_position, output ready);
endinterface

`default_nettype wire

>>> hdl/lcfs_ctrl.sv
// ----------------------------------------------------------------------------
// LED cube frame store controller
// Sequences capture and execution of one item and owns the result valid.
// ----------------------------------------------------------------------------
`default_nettype none

module lcfs_ctrl
  import lcfs_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  output logic           in_ready_o,
  output logic           out_valid_o,
  input  wire logic      out_ready_i,
  output lcfs_ctl_t      ctl_o
);

  lcfs_state_e state_q, state_d;
  logic        out_valid_q, out_valid_d;
  logic        out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    in_ready_o = 1'b0;
    ctl_o      = '0;
    out_free   = !out_valid_q || out_ready_i;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          ctl_o.load = 1'b1;
          state_d    = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (out_free) begin
          ctl_o.exec = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
    if (ctl_o.exec) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire

>>> hdl/lcfs_datapath.sv
// ----------------------------------------------------------------------------
// LED cube frame store datapath
// Voxel store, status registers, command decode and plane word gather.
// ----------------------------------------------------------------------------
`default_nettype none

module lcfs_datapath
  import lcfs_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire lcfs_ctl_t   ctl_i,
  input  wire logic [1:0]  op_i,
  input  wire logic [7:0]  rx_byte_i,
  input  wire logic [1:0]  layer_sel_i,
  input  wire logic [2:0]  plane_sel_i,
  output logic [15:0]      plane_word_o,
  output logic             lamp_on_o,
  output logic [1:0]       pattern_select_o,
  output logic             host_active_o,
  output logic [5:0]       write_position_o
);

  // captured item
  lcfs_op_e    op_q;
  logic [7:0]  rx_q;
  logic [1:0]  layer_q;
  logic [2:0]  plane_q;

  // status
  logic [5:0]  pos_q, pos_d;
  logic        en_q, en_d;
  logic [1:0]  pat_q, pat_d;
  logic [7:0]  tmo_q, tmo_d;

  // store: one small array per lane, indexed by layer
  logic [INT_W-1:0] store_q [LANES][ROWS];
  logic [VOXELS-1:0] vld_q;
  logic              wr_en;
  logic              clr_en;

  logic [15:0] word;
  logic [INT_W-1:0] vox;

  always_ff @(posedge clk_i) begin
    if (ctl_i.load) begin
      op_q    <= lcfs_op_e'(op_i);
      rx_q    <= rx_byte_i;
      layer_q <= layer_sel_i;
      plane_q <= plane_sel_i;
    end
  end

  always_comb begin
    pos_d  = pos_q;
    en_d   = en_q;
    pat_d  = pat_q;
    tmo_d  = tmo_q;
    wr_en  = 1'b0;
    clr_en = 1'b0;
    unique case (op_q)
      OP_BYTE: begin
        if (!rx_q[7]) begin
          tmo_d = TMO_RELOAD;
          wr_en = 1'b1;
          pos_d = pos_q + 6'd1;
        end else if (rx_q[6]) begin
          pos_d = rx_q[5:0];
        end else begin
          case (rx_q[5:0])
            CMD_HOME:  pos_d = '0;
            CMD_OFF:   en_d = 1'b0;
            CMD_ON:    en_d = 1'b1;
            CMD_NEXT: begin
              pat_d  = pat_q + 2'd1;
              clr_en = 1'b1;
            end
            CMD_CLEAR: clr_en = 1'b1;
            CMD_PING:  tmo_d = TMO_RELOAD;
            default:   ;
          endcase
        end
      end
      OP_TICK: begin
        if (tmo_q != 8'd0) tmo_d = tmo_q - 8'd1;
      end
      OP_PLANE, OP_NONE: ;
      default: ;
    endcase
  end

  always_comb begin
    word = '0;
    vox  = '0;
    if (op_q == OP_PLANE && int'(layer_q) < LAYERS && plane_q != 3'd7) begin
      for (int p = 0; p < LANES; p++) begin
        vox = vld_q[{layer_q, 4'(p)}] ? store_q[p][layer_q] : '0;
        word[DRV_MAP[p]] = vox[plane_q];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.exec && wr_en) begin
      store_q[pos_q[3:0]][pos_q[5:4]] <= rx_q[INT_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
      pos_q <= '0;
      en_q  <= 1'b1;
      pat_q <= '0;
      tmo_q <= '0;
    end else if (ctl_i.exec) begin
      if (clr_en) begin
        vld_q <= '0;
      end else if (wr_en) begin
        vld_q[pos_q] <= 1'b1;
      end
      pos_q <= pos_d;
      en_q  <= en_d;
      pat_q <= pat_d;
      tmo_q <= tmo_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.exec) begin
      plane_word_o     <= word;
      lamp_on_o        <= en_d;
      pattern_select_o <= pat_d;
      host_active_o    <= (tmo_d != 8'd0);
      write_position_o <= pos_d;
    end
  end

endmodule

`default_nettype wire

>>> hdl/led_cube_command_frame_store_unit.sv
// An accepted item is first captured, then executed into the result register.
// The controller takes a new item only from its idle state, after the last item
//   has executed, and the execute step waits while the result register is full.
// The result register lets the next item be captured while a result waits.
// Reset (rst_ni low, asynchronous): store reads all zero, position zero, display on,
//   pattern zero, host timeout zero, no result pending; no clearing pass.
// ----------------------------------------------------------------------------
// LED cube command and frame store unit
// Serial command decode into a 64-voxel intensity store with bit-plane reads.
// ----------------------------------------------------------------------------
`default_nettype none

module led_cube_command_frame_store_unit
  import lcfs_pkg::*;
(
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  lcfs_in_if.sink     in_i,
  lcfs_out_if.source  out_o
);

  lcfs_ctl_t ctl;

  lcfs_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .ctl_o       (ctl)
  );

  lcfs_datapath u_datapath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .ctl_i            (ctl),
    .op_i             (in_i.op),
    .rx_byte_i        (in_i.rx_byte),
    .layer_sel_i      (in_i.layer_sel),
    .plane_sel_i      (in_i.plane_sel),
    .plane_word_o     (out_o.plane_word),
    .lamp_on_o        (out_o.lamp_on),
    .pattern_select_o (out_o.pattern_select),
    .host_active_o    (out_o.host_active),
    .write_position_o (out_o.write_position)
  );

endmodule

`default_nettype wire

>>> hdl/lcfs_checker.sv
// ----------------------------------------------------------------------------
// LED cube frame store port checker
// Port-level assertions, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "led_cube_command_frame_store_unit_assert.svh"

module lcfs_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        in_valid_i,
  input wire logic        in_ready_i,
  input wire logic        out_valid_i,
  input wire logic        out_ready_i,
  input wire logic [15:0] plane_word_i,
  input wire logic [5:0]  write_position_i
);

  `LCFS_ASSERT(a_one_in_flight, clk_i, rst_ni, (in_valid_i && in_ready_i) |=> !in_ready_i)
  `LCFS_ASSERT(a_result_after_exec, clk_i, rst_ni, $rose(out_valid_i) |-> $past(!in_ready_i))
  `LCFS_ASSERT_HOLD(a_word_hold, clk_i, rst_ni, out_valid_i, out_ready_i, plane_word_i)
  `LCFS_ASSERT_HOLD(a_pos_hold, clk_i, rst_ni, out_valid_i, out_ready_i, write_position_i)

endmodule

bind led_cube_command_frame_store_unit lcfs_checker u_lcfs_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .in_valid_i       (in_i.valid),
  .in_ready_i       (in_i.ready),
  .out_valid_i      (out_o.valid),
  .out_ready_i      (out_o.ready),
  .plane_word_i     (out_o.plane_word),
  .write_position_i (out_o.write_position)
);

`default_nettype wire

>>> tb/led_cube_command_frame_store_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LED cube command and frame store unit testbench
// Drives serial bytes, plane reads and frame ticks through the item channel.
// Every transfer on the result channel is checked field by field against an
// in-order predictor of the voxel store and status registers. A directed
// table comes first, then mixed random traffic under changing back-pressure.
// ----------------------------------------------------------------------------

module led_cube_command_frame_store_unit_tb;
  import lcfs_pkg::*;

  localparam logic [5:0] CMD_UNKNOWN_LO = 6'd6;
  localparam logic [5:0] CMD_UNKNOWN_HI = 6'd63;
  localparam int         RANDOM_ITEMS   = 252;
  localparam int         TICK_RUN       = 256;

  typedef struct packed {
    lcfs_op_e   op;
    logic [7:0] rx;
    logic [1:0] layer;
    logic [2:0] plane;
  } cube_item_t;

  typedef struct packed {
    logic [15:0] plane_word;
    logic        lamp_on;
    logic [1:0]  pattern_select;
    logic        host_active;
    logic [5:0]  write_position;
  } cube_status_t;

  typedef struct packed {
    cube_item_t   item;
    logic         typed;
    cube_status_t want;
  } cube_row_t;

  logic clk_i;
  logic rst_ni;

  lcfs_in_if  in_ch ();
  lcfs_out_if out_ch ();

  led_cube_command_frame_store_unit dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch),
    .out_o  (out_ch)
  );

  // predictor state
  logic [6:0]   voxel_mem [VOXELS];
  logic [5:0]   write_pos;
  logic         lamp;
  logic [1:0]   pattern;
  logic [7:0]   host_tmo;

  cube_status_t pending_status_q [$];
  cube_row_t    dir_rows [$];
  logic         row_typed;
  cube_status_t row_want;
  int           err_count;
  int           send_idle_pct;
  int           recv_idle_pct;
  int           hold_cycles;

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    #1_000_000;
    $display("led_cube_command_frame_store_unit test failed");
    $finish;
  end

  function automatic cube_status_t predict_status(cube_item_t it);
    cube_status_t st;
    logic [5:0]   code;
    st   = '0;
    code = it.rx[5:0];
    case (it.op)
      OP_BYTE: begin
        if (!it.rx[7]) begin
          host_tmo             = TMO_RELOAD;
          voxel_mem[write_pos] = it.rx[6:0];
          write_pos            = write_pos + 6'd1;
        end else if (it.rx[6]) begin
          write_pos = code;
        end else begin
          case (code)
            CMD_HOME:  write_pos = '0;
            CMD_OFF:   lamp = 1'b0;
            CMD_ON:    lamp = 1'b1;
            CMD_NEXT: begin
              pattern   = pattern + 2'd1;
              voxel_mem = '{default: '0};
            end
            CMD_CLEAR: voxel_mem = '{default: '0};
            CMD_PING:  host_tmo = TMO_RELOAD;
            default: ;
          endcase
        end
      end
      OP_PLANE: begin
        if (it.layer < LAYERS && it.plane < INT_W) begin
          for (int p = 0; p < LANES; p++) begin
            st.plane_word[DRV_MAP[p]] = voxel_mem[it.layer * LANES + p][it.plane];
          end
        end
      end
      OP_TICK: begin
        if (host_tmo != 8'd0) host_tmo = host_tmo - 8'd1;
      end
      default: ;
    endcase
    st.lamp_on        = lamp;
    st.pattern_select = pattern;
    st.host_active    = (host_tmo != 8'd0);
    st.write_position = write_pos;
    return st;
  endfunction

  function automatic cube_status_t mk_status(logic [15:0] word, logic on, logic [1:0] pat,
                                             logic act, logic [5:0] pos);
    return '{plane_word: word, lamp_on: on, pattern_select: pat, host_active: act,
             write_position: pos};
  endfunction

  function automatic cube_row_t mk_row(lcfs_op_e op, logic [7:0] rx, logic [1:0] layer,
                                       logic [2:0] plane, logic typed = 1'b0,
                                       cube_status_t want = '0);
    return '{item: '{op: op, rx: rx, layer: layer, plane: plane}, typed: typed, want: want};
  endfunction

  function automatic logic [7:0] cmd_byte(logic [5:0] code);
    return {2'b10, code};
  endfunction

  function automatic cube_item_t rand_item();
    cube_item_t it;
    int         sel;
    logic [5:0] code;
    it.op    = OP_BYTE;
    it.rx    = 8'($urandom);
    it.layer = 2'($urandom);
    it.plane = 3'($urandom);
    sel      = $urandom_range(99);
    if (sel < 40) begin
      it.rx[7] = 1'b0;
    end else if (sel < 70) begin
      it.op = OP_PLANE;
    end else if (sel < 80) begin
      it.op = OP_TICK;
    end else if (sel < 88) begin
      code = 6'($urandom_range(CMD_PING));
      if ((code == CMD_NEXT || code == CMD_CLEAR) && $urandom_range(2) != 0) code = CMD_PING;
      it.rx = cmd_byte(code);
    end else if (sel < 91) begin
      it.rx = cmd_byte(6'($urandom_range(CMD_UNKNOWN_HI, CMD_UNKNOWN_LO)));
    end else if (sel < 96) begin
      it.rx[7:6] = 2'b11;
    end else if (sel >= 98) begin
      it.op = OP_NONE;
    end
    return it;
  endfunction

  task automatic report_fail(string msg);
    $display("ERROR %0t: %s", $realtime, msg);
    err_count++;
  endtask

  task automatic send_item(cube_item_t it, logic typed, cube_status_t want);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_ch.valid     <= 1'b1;
    in_ch.op        <= it.op;
    in_ch.rx_byte   <= it.rx;
    in_ch.layer_sel <= it.layer;
    in_ch.plane_sel <= it.plane;
    row_typed       <= typed;
    row_want        <= want;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
  endtask

  task automatic pause_until_drained();
    in_ch.valid <= 1'b0;
    do @(posedge clk_i); while (pending_status_q.size() != 0);
  endtask

  task automatic run_random(int count);
    repeat (count) send_item(rand_item(), 1'b0, '0);
  endtask

  // result channel back-pressure
  initial begin
    int n;
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_cycles != 0) begin
        n           = hold_cycles;
        hold_cycles = 0;
        out_ch.ready <= 1'b0;
        repeat (n) @(posedge clk_i);
      end else begin
        out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // transfer monitor and scoreboard
  always @(posedge clk_i) begin
    cube_status_t got_st;
    cube_status_t want_st;
    cube_item_t   acc;
    if (rst_ni) begin
      if (out_ch.valid && out_ch.ready) begin
        got_st = mk_status(out_ch.plane_word, out_ch.lamp_on, out_ch.pattern_select,
                           out_ch.host_active, out_ch.write_position);
        if (pending_status_q.size() == 0) begin
          report_fail($sformatf("unexpected result %h", got_st));
        end else begin
          want_st = pending_status_q.pop_front();
          if (got_st.plane_word != want_st.plane_word)
            report_fail($sformatf("plane_word got %h want %h",
                                  got_st.plane_word, want_st.plane_word));
          if (got_st.lamp_on != want_st.lamp_on)
            report_fail($sformatf("lamp_on got %b want %b",
                                  got_st.lamp_on, want_st.lamp_on));
          if (got_st.pattern_select != want_st.pattern_select)
            report_fail($sformatf("pattern_select got %0d want %0d",
                                  got_st.pattern_select, want_st.pattern_select));
          if (got_st.host_active != want_st.host_active)
            report_fail($sformatf("host_active got %b want %b",
                                  got_st.host_active, want_st.host_active));
          if (got_st.write_position != want_st.write_position)
            report_fail($sformatf("write_position got %0d want %0d",
                                  got_st.write_position, want_st.write_position));
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        acc     = '{op: lcfs_op_e'(in_ch.op), rx: in_ch.rx_byte, layer: in_ch.layer_sel,
                    plane: in_ch.plane_sel};
        want_st = predict_status(acc);
        pending_status_q.push_back(row_typed ? row_want : want_st);
      end
    end
  end

  initial begin
    in_ch.valid     = 1'b0;
    in_ch.op        = OP_NONE;
    in_ch.rx_byte   = '0;
    in_ch.layer_sel = '0;
    in_ch.plane_sel = '0;
    row_typed       = 1'b0;
    row_want        = '0;
    err_count       = 0;
    hold_cycles     = 0;
    send_idle_pct   = 28;
    recv_idle_pct   = 63;
    voxel_mem       = '{default: '0};
    write_pos       = '0;
    lamp            = 1'b1;
    pattern         = '0;
    host_tmo        = '0;
    rst_ni          = 1'b0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // after reset, tick at zero, unknown op
    dir_rows.push_back(mk_row(OP_PLANE, 8'h00, 2'd0, 3'd0, 1'b1, mk_status('0, 1, 0, 0, 0)));
    dir_rows.push_back(mk_row(OP_TICK,  8'h00, 2'd0, 3'd0, 1'b1, mk_status('0, 1, 0, 0, 0)));
    dir_rows.push_back(mk_row(OP_NONE,  8'hFF, 2'd3, 3'd7, 1'b1, mk_status('0, 1, 0, 0, 0)));
    // data extremes, position load, wrap at the top
    dir_rows.push_back(mk_row(OP_BYTE,  8'h7F, 2'd0, 3'd0, 1'b1, mk_status('0, 1, 0, 1, 1)));
    dir_rows.push_back(mk_row(OP_BYTE,  8'hFF, 2'd0, 3'd0, 1'b1, mk_status('0, 1, 0, 1, 63)));
    dir_rows.push_back(mk_row(OP_BYTE,  8'h7F, 2'd0, 3'd0, 1'b1, mk_status('0, 1, 0, 1, 0)));
    // plane seven reads zero
    dir_rows.push_back(mk_row(OP_PLANE, 8'h00, 2'd3, 3'd7, 1'b1, mk_status('0, 1, 0, 1, 0)));
    dir_rows.push_back(mk_row(OP_PLANE, 8'h00, 2'd0, 3'd6));
    dir_rows.push_back(mk_row(OP_PLANE, 8'h00, 2'd3, 3'd6));
    dir_rows.push_back(mk_row(OP_BYTE,  8'h00, 2'd0, 3'd0));
    dir_rows.push_back(mk_row(OP_BYTE,  8'h55, 2'd0, 3'd0));
    dir_rows.push_back(mk_row(OP_BYTE,  8'h2A, 2'd0, 3'd0));
    dir_rows.push_back(mk_row(OP_PLANE, 8'h00, 2'd0, 3'd0));
    dir_rows.push_back(mk_row(OP_PLANE, 8'h00, 2'd0, 3'd1));
    dir_rows.push_back(mk_row(OP_BYTE,  cmd_byte(CMD_OFF), 2'd0, 3'd0, 1'b1,
                              mk_status('0, 0, 0, 1, 3)));
    dir_rows.push_back(mk_row(OP_PLANE, 8'h00, 2'd0, 3'd0));
    dir_rows.push_back(mk_row(OP_BYTE,  cmd_byte(CMD_ON), 2'd0, 3'd0));
    dir_rows.push_back(mk_row(OP_BYTE,  cmd_byte(CMD_NEXT), 2'd0, 3'd0));
    dir_rows.push_back(mk_row(OP_PLANE, 8'h00, 2'd3, 3'd6));
    dir_rows.push_back(mk_row(OP_BYTE,  8'h3C, 2'd0, 3'd0));
    dir_rows.push_back(mk_row(OP_BYTE,  cmd_byte(CMD_CLEAR), 2'd0, 3'd0));
    dir_rows.push_back(mk_row(OP_BYTE,  cmd_byte(CMD_PING), 2'd0, 3'd0));
    dir_rows.push_back(mk_row(OP_BYTE,  cmd_byte(CMD_HOME), 2'd0, 3'd0));
    // unknown command codes
    dir_rows.push_back(mk_row(OP_BYTE,  cmd_byte(CMD_UNKNOWN_LO), 2'd0, 3'd0));
    dir_rows.push_back(mk_row(OP_BYTE,  cmd_byte(CMD_UNKNOWN_HI), 2'd0, 3'd0));
    dir_rows.push_back(mk_row(OP_TICK,  8'h00, 2'd0, 3'd0));

    foreach (dir_rows[i]) send_item(dir_rows[i].item, dir_rows[i].typed, dir_rows[i].want);

    run_random(RANDOM_ITEMS);
    pause_until_drained();

    // long result stall while items keep coming
    send_idle_pct = 0;
    hold_cycles   = 48;
    run_random(12);
    pause_until_drained();

    send_idle_pct = 63;
    recv_idle_pct = 28;
    run_random(RANDOM_ITEMS);
    pause_until_drained();

    // host timeout runs out
    send_idle_pct = 0;
    recv_idle_pct = 0;
    send_item('{op: OP_BYTE, rx: 8'h11, layer: 2'd0, plane: 3'd0}, 1'b0, '0);
    repeat (TICK_RUN) send_item('{op: OP_TICK, rx: 8'($urandom), layer: 2'($urandom),
                                  plane: 3'($urandom)}, 1'b0, '0);
    run_random(RANDOM_ITEMS);

    pause_until_drained();
    repeat (8) @(posedge clk_i);
    if (err_count == 0) begin
      $display("led_cube_command_frame_store_unit test passed");
    end else begin
      $display("led_cube_command_frame_store_unit test failed");
    end
    $finish;
  end

endmodule

>>> led_cube_command_frame_store_unit.f
+incdir+hdl
hdl/lcfs_pkg.sv
hdl/lcfs_if.sv
hdl/lcfs_ctrl.sv
hdl/lcfs_datapath.sv
hdl/led_cube_command_frame_store_unit.sv
hdl/lcfs_checker.sv
tb/led_cube_command_frame_store_unit_tb.sv
